FILE: hw/rtl/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// Used by tcpq_ring and two_class_priority_queue; depends on nothing.
`default_nettype none

package tcpq_pkg;

  localparam int VALUE_W = 16;
  localparam int REQ_W   = 2;
  localparam int COUNT_W = 6;

  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [VALUE_W-1:0] THRESH_RESET = 16'hFFFF;

  // Request from the control logic to one class ring.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic [VALUE_W-1:0] data;
  } ring_cmd_t;

  // What one ring reports back about its contents.
  typedef struct packed {
    logic               empty;
    logic               full;
    logic [VALUE_W-1:0] head;
    logic [VALUE_W-1:0] tail;
  } ring_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcpq_ring.sv
// One class FIFO: a ring store in a synchronous RAM with cached head and tail.
// Depends on tcpq_pkg for the command and status structs.
`default_nettype none

module tcpq_ring
  import tcpq_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ring_cmd_t        cmd,
  output ring_stat_t            stat,
  output logic      [CNT_W-1:0] fill
);

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]   rd_ptr_r, wr_ptr_r;
  logic [PTR_W-1:0]   rd_next, wr_next;
  logic [CNT_W-1:0]   fill_r;
  logic               refresh_r;
  logic [VALUE_W-1:0] rd_data_r;
  logic [VALUE_W-1:0] head_r, tail_r;

  assign rd_next = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
  assign wr_next = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);

  // A pop fetches the entry behind the old head into rd_data_r, and the
  // cached head is then refreshed from that register.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr_r] <= cmd.data;
    end
    if (cmd.pop) begin
      rd_data_r <= mem[rd_next];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      fill_r    <= '0;
      refresh_r <= 1'b0;
    end else begin
      refresh_r <= cmd.pop;
      if (cmd.push) begin
        wr_ptr_r <= wr_next;
        fill_r   <= fill_r + CNT_W'(1);
      end else if (cmd.pop) begin
        rd_ptr_r <= rd_next;
        fill_r   <= fill_r - CNT_W'(1);
      end
    end
  end

  // An item pushed into an empty ring is its head as well as its tail.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tail_r <= cmd.data;
      if (fill_r == '0) begin
        head_r <= cmd.data;
      end
    end else if (refresh_r) begin
      head_r <= rd_data_r;
    end
  end

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == CNT_W'(DEPTH));
  assign stat.head  = head_r;
  assign stat.tail  = tail_r;
  assign fill       = fill_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("ring fill count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.full)
    else $error("push issued to a full ring");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.empty)
    else $error("pop issued to an empty ring");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.pop))
    else $error("push and pop issued in the same cycle");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/two_class_priority_queue.sv
// Top level of the two-class priority queue: request control, threshold
// register and result register. Depends on tcpq_pkg and tcpq_ring.
`default_nettype none

// Each request item (query, insert or remove) passes through S_IDLE, S_FETCH
// and S_WRITE on its way to its result: the ring pointers and the RAM write
// or read move in the cycle of acceptance, in S_IDLE; the refreshed head is
// loaded from the RAM read port in S_FETCH; and the result is loaded into the
// output register in S_WRITE, which waits there while a pending result is
// stalled. The next item may be accepted as soon as that result is loaded,
// even while it still waits on out_stall. Values at or above the threshold
// register go to the priority class; each class holds CLASS_DEPTH entries
// and an insert into a full class is dropped with full_error set. The RAMs
// need no clearing after reset.
module two_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int CLASS_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_wr_en,
  input  wire logic [VALUE_W-1:0] cfg_wr_data,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [REQ_W-1:0]   in_req_type,
  input  wire logic [VALUE_W-1:0] in_item_value,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_removed_valid,
  output logic      [VALUE_W-1:0] out_removed_value,
  output logic                    out_empty_error,
  output logic                    out_full_error,
  output logic      [VALUE_W-1:0] out_head_value,
  output logic      [VALUE_W-1:0] out_tail_value,
  output logic      [VALUE_W-1:0] out_prio_head_value,
  output logic      [VALUE_W-1:0] out_prio_tail_value,
  output logic                    out_has_priority,
  output logic      [COUNT_W-1:0] out_entry_count
);

  localparam int CNT_W = $clog2(CLASS_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [VALUE_W-1:0] thresh_r;

  ring_cmd_t  pcmd, ncmd;
  ring_stat_t pstat, nstat;
  logic [CNT_W-1:0] pfill, nfill;

  logic               in_accept;
  logic               is_prio;
  logic               rvalid_c, eerr_c, ferr_c;
  logic [VALUE_W-1:0] rval_c;

  logic               rvalid_r, eerr_r, ferr_r;
  logic [VALUE_W-1:0] rval_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic               out_rvalid_r, out_eerr_r, out_ferr_r, out_has_prio_r;
  logic [VALUE_W-1:0] out_rval_r, out_head_r, out_tail_r;
  logic [VALUE_W-1:0] out_phead_r, out_ptail_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [VALUE_W-1:0] head_c, tail_c, phead_c, ptail_c;
  logic [CNT_W:0]     count_sum;

  tcpq_ring #(.DEPTH(CLASS_DEPTH)) u_prio_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (pcmd),
    .stat  (pstat),
    .fill  (pfill)
  );

  tcpq_ring #(.DEPTH(CLASS_DEPTH)) u_norm_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ncmd),
    .stat  (nstat),
    .fill  (nfill)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  assign in_accept = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign is_prio   = (in_item_value >= thresh_r);

  always_comb begin
    pcmd      = '0;
    ncmd      = '0;
    pcmd.data = in_item_value;
    ncmd.data = in_item_value;
    rvalid_c  = 1'b0;
    rval_c    = '0;
    eerr_c    = 1'b0;
    ferr_c    = 1'b0;
    unique case (in_req_type)
      REQ_INSERT: begin
        if (is_prio) begin
          pcmd.push = in_accept && !pstat.full;
          ferr_c    = pstat.full;
        end else begin
          ncmd.push = in_accept && !nstat.full;
          ferr_c    = nstat.full;
        end
      end
      REQ_REMOVE: begin
        priority if (!pstat.empty) begin
          pcmd.pop = in_accept;
          rvalid_c = 1'b1;
          rval_c   = pstat.head;
        end else if (!nstat.empty) begin
          ncmd.pop = in_accept;
          rvalid_c = 1'b1;
          rval_c   = nstat.head;
        end else begin
          eerr_c = 1'b1;
        end
      end
      default: begin
        // Query, and the unused code, leave the queue as it is.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rvalid_r <= rvalid_c;
      rval_r   <= rval_c;
      eerr_r   <= eerr_c;
      ferr_r   <= ferr_c;
    end
  end

  // The view of the queue after the step, zero where there is nothing to show.
  always_comb begin
    phead_c = pstat.empty ? '0 : pstat.head;
    ptail_c = pstat.empty ? '0 : pstat.tail;
    head_c  = !pstat.empty ? pstat.head : (!nstat.empty ? nstat.head : '0);
    tail_c  = !nstat.empty ? nstat.tail : ptail_c;
  end

  assign count_sum = {1'b0, pfill} + {1'b0, nfill};

  assign out_load = (state_r == S_WRITE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rvalid_r   <= rvalid_r;
      out_rval_r     <= rval_r;
      out_eerr_r     <= eerr_r;
      out_ferr_r     <= ferr_r;
      out_head_r     <= head_c;
      out_tail_r     <= tail_c;
      out_phead_r    <= phead_c;
      out_ptail_r    <= ptail_c;
      out_has_prio_r <= !pstat.empty;
      out_count_r    <= COUNT_W'(count_sum);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_removed_valid   = out_rvalid_r;
  assign out_removed_value   = out_rval_r;
  assign out_empty_error     = out_eerr_r;
  assign out_full_error      = out_ferr_r;
  assign out_head_value      = out_head_r;
  assign out_tail_value      = out_tail_r;
  assign out_prio_head_value = out_phead_r;
  assign out_prio_tail_value = out_ptail_r;
  assign out_has_priority    = out_has_prio_r;
  assign out_entry_count     = out_count_r;

`ifndef SYNTHESIS
  a_result_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_removed_valid && out_empty_error))
    else $error("result reports both a removal and an empty error");

  a_accept_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_FETCH))
    else $error("accepted item did not move on to the fetch cycle");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !out_load)
    else $error("result register overwritten while its item was stalled");

  a_removed_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_head_value != '0) |-> (out_entry_count != '0))
    else $error("non-zero head shown for an empty queue");
`endif

endmodule

`default_nettype wire
